@@ design/orb_pkg.sv @@
// ----------------------------------------------------------------------------
// orb_pkg
// Shared types and constants for the overwriting ring buffer.
// ----------------------------------------------------------------------------
package orb_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = 5;
  localparam int KIND_W    = 3;
  localparam int IDX_W     = 4;
  localparam int ERR_W     = 2;

  // Operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH  = 3'd0,
    KIND_POP   = 3'd1,
    KIND_CLEAR = 3'd2,
    KIND_READ  = 3'd3,
    KIND_WRITE = 3'd4
  } kind_t;

  // Error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_INDEX = 2'd1,
    ERR_EMPTY = 2'd2,
    ERR_ZCAP  = 2'd3
  } err_t;

  // Slot memory access request
  typedef struct packed {
    logic                 we;
    logic                 re;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] wdata;
  } mem_req_t;

  // Registered result word, read data joined in at the top level
  typedef struct packed {
    logic             valid;
    logic             rd_sel;
    logic [CNT_W-1:0] count;
    logic             full;
    logic             ovw;
    err_t             err;
  } res_t;

endpackage

@@ design/orb_ram.sv @@
// ----------------------------------------------------------------------------
// orb_ram
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module orb_ram #(
  parameter int DEPTH_P = 16,
  parameter int WIDTH_P = 32
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [$clog2(DEPTH_P)-1:0] addr,
  input  logic [WIDTH_P-1:0]         wdata,
  output logic [WIDTH_P-1:0]         rdata
);

  logic [WIDTH_P-1:0] mem [DEPTH_P];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ design/orb_ctrl.sv @@
// ----------------------------------------------------------------------------
// orb_ctrl
// Head/count pointers, logical-to-slot mapping, error checks and the
// registered result word.
// ----------------------------------------------------------------------------
module orb_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [orb_pkg::KIND_W-1:0]    kind,
  input  logic [orb_pkg::IDX_W-1:0]     index,
  input  logic [orb_pkg::WORD_BITS-1:0] value,
  input  logic                          cfg_we,
  input  logic [orb_pkg::CNT_W-1:0]     cfg_data,
  output orb_pkg::mem_req_t             mem_req,
  output orb_pkg::res_t                 res
);
  import orb_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0]  held_r, held_nxt;
  logic [CNT_W-1:0]  cap_r,  cap_nxt;
  res_t              res_r,  res_nxt;

  logic [CNT_W-1:0]  head_ext;
  logic [CNT_W-1:0]  head_inc;
  logic [ADDR_W-1:0] head_adv;
  logic [CNT_W-1:0]  off;
  logic [CNT_W-1:0]  sum;
  logic [CNT_W-1:0]  slot;
  logic              idx_ok;

  // slot = (head + offset) mod cap; both terms stay below cap
  assign head_ext = CNT_W'(head_r);
  assign head_inc = head_ext + CNT_W'(1);
  assign head_adv = (head_inc >= cap_r) ? '0 : head_inc[ADDR_W-1:0];
  assign off      = (kind_t'(kind) == KIND_PUSH) ? held_r : CNT_W'(index);
  assign sum      = head_ext + off;
  assign slot     = (sum >= cap_r) ? (sum - cap_r) : sum;
  assign idx_ok   = CNT_W'(index) < held_r;

  // operation decode
  always_comb begin
    head_nxt      = head_r;
    held_nxt      = held_r;
    cap_nxt       = cap_r;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = slot[ADDR_W-1:0];
    mem_req.wdata = value;
    res_nxt       = '0;
    res_nxt.err   = ERR_NONE;

    if (cfg_we) begin
      cap_nxt  = (cfg_data > DEPTH_C) ? DEPTH_C : cfg_data;
      head_nxt = '0;
      held_nxt = '0;
    end else if (accept) begin
      res_nxt.valid = 1'b1;
      case (kind)
        KIND_PUSH: begin
          if (cap_r == '0) begin
            res_nxt.err = ERR_ZCAP;
          end else if (held_r < cap_r) begin
            mem_req.we = 1'b1;
            held_nxt   = held_r + CNT_W'(1);
          end else begin
            // full: replace oldest, head moves on
            mem_req.we   = 1'b1;
            mem_req.addr = head_r;
            head_nxt     = head_adv;
            res_nxt.ovw  = 1'b1;
          end
        end
        KIND_POP: begin
          if (held_r == '0) begin
            res_nxt.err = ERR_EMPTY;
          end else begin
            held_nxt = held_r - CNT_W'(1);
            head_nxt = (held_r == CNT_W'(1)) ? '0 : head_adv;
          end
        end
        KIND_CLEAR: begin
          held_nxt = '0;
          head_nxt = '0;
        end
        KIND_READ: begin
          if (!idx_ok) begin
            res_nxt.err = ERR_INDEX;
          end else begin
            mem_req.re     = 1'b1;
            res_nxt.rd_sel = 1'b1;
          end
        end
        KIND_WRITE: begin
          if (!idx_ok) begin
            res_nxt.err = ERR_INDEX;
          end else begin
            mem_req.we = 1'b1;
          end
        end
        default: begin
        end
      endcase
      res_nxt.count = held_nxt;
      res_nxt.full  = (held_nxt == cap_r);
    end
  end

  // pointer and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      held_r <= '0;
      cap_r  <= DEPTH_C;
      res_r  <= '0;
    end else begin
      head_r <= head_nxt;
      held_r <= held_nxt;
      cap_r  <= cap_nxt;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ design/overwriting_ring_buffer_top.sv @@
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_top
// Ring buffer of data words that overwrites the oldest entry when full.
// Each word's result strobes on out_valid in the cycle after start.
// Throughput: one word per cycle; busy stays low, at most one slot RAM access a word.
// Reset (rst_n low, synchronous): buffer empty, head 0, capacity 16.
// Slot contents are not cleared; results are never stalled by the receiver.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [orb_pkg::KIND_W-1:0]    in_kind,
  input  logic [orb_pkg::IDX_W-1:0]     in_index,
  input  logic [orb_pkg::WORD_BITS-1:0] in_value,
  input  logic                          cfg_we,
  input  logic [orb_pkg::CNT_W-1:0]     cfg_data,
  output logic                          out_valid,
  output logic [orb_pkg::WORD_BITS-1:0] out_read_data,
  output logic [orb_pkg::CNT_W-1:0]     out_count,
  output logic                          out_full_res,
  output logic                          out_overwrote,
  output logic [orb_pkg::ERR_W-1:0]     out_error
);
  import orb_pkg::*;

  mem_req_t             mem_req;
  res_t                 res;
  logic [WORD_BITS-1:0] rdata;

  assign busy = 1'b0;

  orb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (start && !busy),
    .kind     (in_kind),
    .index    (in_index),
    .value    (in_value),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .mem_req  (mem_req),
    .res      (res)
  );

  orb_ram #(
    .DEPTH_P (DEPTH),
    .WIDTH_P (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .re    (mem_req.re),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (rdata)
  );

  // result word; read data only for a successful read
  assign out_valid     = res.valid;
  assign out_read_data = res.rd_sel ? rdata : '0;
  assign out_count     = res.count;
  assign out_full_res  = res.full;
  assign out_overwrote = res.ovw;
  assign out_error     = res.err;

endmodule

@@ dv/overwriting_ring_buffer_top_test.sv @@
// ----------------------------------------------------------------------------
// overwriting_ring_buffer_top_test
// Self-checking bench for the overwriting ring buffer. Words go in through the
// start/busy port, a behavioral copy of the ring predicts each result, and a
// monitor compares every strobed result field by field with the oldest
// prediction. Directed corner cases come first, then random traffic over a
// range of capacities, with random sender gaps and a final burst without any.
// ----------------------------------------------------------------------------
module overwriting_ring_buffer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import orb_pkg::*;

  localparam int RESET_CYCLES = 7;
  localparam int MAX_SHOWN    = 10;
  localparam int TAIL_CYCLES  = 4;

  // One predicted result
  typedef struct {
    logic [WORD_BITS-1:0] read_data;
    logic [CNT_W-1:0]     count;
    logic                 full;
    logic                 ovw;
    err_t                 error;
  } ring_res_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [KIND_W-1:0]    in_kind;
  logic [IDX_W-1:0]     in_index;
  logic [WORD_BITS-1:0] in_value;
  logic                 cfg_we;
  logic [CNT_W-1:0]     cfg_data;
  logic                 out_valid;
  logic [WORD_BITS-1:0] out_read_data;
  logic [CNT_W-1:0]     out_count;
  logic                 out_full_res;
  logic                 out_overwrote;
  logic [ERR_W-1:0]     out_error;

  // Predictor state: slot memory, head, fill level, capacity register
  logic [WORD_BITS-1:0] slot_mem [DEPTH];
  int                   head_slot;
  int                   held_cnt;
  logic [CNT_W-1:0]     cap_reg;

  ring_res_t            pending_q[$];
  int                   mismatches;

  overwriting_ring_buffer_top i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_kind       (in_kind),
    .in_index      (in_index),
    .in_value      (in_value),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_count     (out_count),
    .out_full_res  (out_full_res),
    .out_overwrote (out_overwrote),
    .out_error     (out_error)
  );

  always #4 clk = ~clk;

  // Apply one word to the predicted ring and return the result it should give
  function automatic ring_res_t apply_word(logic [KIND_W-1:0] k, logic [IDX_W-1:0] idx,
                                           logic [WORD_BITS-1:0] val);
    ring_res_t r;
    int        cap;
    r.read_data = '0;
    r.ovw       = 1'b0;
    r.error     = ERR_NONE;
    cap = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
    case (k)
      KIND_PUSH: begin
        if (cap == 0) begin
          r.error = ERR_ZCAP;
        end else if (held_cnt < cap) begin
          slot_mem[(head_slot + held_cnt) % cap] = val;
          held_cnt++;
        end else begin
          // full: oldest entry is replaced and the head moves on
          slot_mem[head_slot % cap] = val;
          head_slot = (head_slot + 1) % cap;
          r.ovw = 1'b1;
        end
      end
      KIND_POP: begin
        if (held_cnt == 0) begin
          r.error = ERR_EMPTY;
        end else begin
          head_slot = (head_slot + 1) % cap;
          held_cnt--;
          if (held_cnt == 0) head_slot = 0;
        end
      end
      KIND_CLEAR: begin
        held_cnt  = 0;
        head_slot = 0;
      end
      KIND_READ: begin
        if (int'(idx) >= held_cnt) r.error = ERR_INDEX;
        else r.read_data = slot_mem[(head_slot + int'(idx)) % cap];
      end
      KIND_WRITE: begin
        if (int'(idx) >= held_cnt) r.error = ERR_INDEX;
        else slot_mem[(head_slot + int'(idx)) % cap] = val;
      end
      default: ; // unused kinds do nothing
    endcase
    r.count = CNT_W'(held_cnt);
    r.full  = (held_cnt == cap);
    return r;
  endfunction

  // Result checking, then predictor update for config writes and accepted words
  always @(posedge clk) begin : result_monitor
    ring_res_t want;
    if (!rst_n) begin
      head_slot = 0;
      held_cnt  = 0;
      cap_reg   = CNT_W'(DEPTH);
    end else begin
      if (out_valid) begin
        if (pending_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("%0t: result with nothing expected: data %h count %0d", $realtime,
                     out_read_data, out_count);
        end else begin
          want = pending_q[0];
          pending_q.delete(0);
          if (out_read_data !== want.read_data || out_count !== want.count ||
              out_full_res !== want.full || out_overwrote !== want.ovw ||
              out_error !== want.error) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("%0t: mismatch exp data %h cnt %0d full %b ovw %b err %0d / got %h %0d %b %b %0d",
                       $realtime, want.read_data, want.count, want.full, want.ovw, want.error,
                       out_read_data, out_count, out_full_res, out_overwrote, out_error);
          end
        end
      end
      if (cfg_we) begin
        cap_reg   = cfg_data;
        head_slot = 0;
        held_cnt  = 0;
      end
      if (start && !busy) pending_q.push_back(apply_word(in_kind, in_index, in_value));
    end
  end

  // Drive one word and hold it until the block takes it
  task automatic send_word(input logic [KIND_W-1:0] k, input logic [IDX_W-1:0] idx,
                           input logic [WORD_BITS-1:0] val);
    @(negedge clk);
    start    <= 1'b1;
    in_kind  <= k;
    in_index <= idx;
    in_value <= val;
    do @(posedge clk); while (busy);
  endtask

  // Sender gap: drop start and wait, n sets the length of the gap
  task automatic pause_cycles(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has come back
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CNT_W-1:0] c);
    drain_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= c;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Random word, mostly legal operations with indexes inside the fill level
  task automatic send_random_word(output bit counted);
    logic [KIND_W-1:0] k;
    logic [IDX_W-1:0]  idx;
    int                pick;
    pick = $urandom_range(99);
    if (pick < 4) k = KIND_W'($urandom_range(7, int'(KIND_WRITE) + 1));
    else if (pick < 42) k = KIND_PUSH;
    else if (pick < 56) k = KIND_POP;
    else if (pick < 59) k = KIND_CLEAR;
    else if (pick < 81) k = KIND_READ;
    else k = KIND_WRITE;
    if (held_cnt > 0 && $urandom_range(9) > 0) idx = IDX_W'($urandom_range(held_cnt - 1, 0));
    else idx = IDX_W'($urandom_range(15, 0));
    send_word(k, idx, $urandom);
    counted = (pick >= 4);
  endtask

  // Every operation at the reset capacity, data extremes and error paths
  task automatic test_basic_ops();
    send_word(KIND_PUSH, '0, '0);
    send_word(KIND_PUSH, '0, '1);
    send_word(KIND_READ, 4'd0, '0);
    send_word(KIND_READ, 4'd1, '0);
    send_word(KIND_READ, 4'd15, '0);              // past the count
    send_word(KIND_WRITE, 4'd1, 32'hA5A5_5A5A);
    send_word(KIND_READ, 4'd1, '0);
    send_word(KIND_WRITE, 4'd9, 32'h5A5A_A5A5);   // past the count
    send_word(KIND_W'(int'(KIND_WRITE) + 1), '1, '1);
    send_word('1, '0, '0);
    send_word(KIND_POP, '0, '0);
    send_word(KIND_POP, '0, '0);                  // empties, head back to 0
    send_word(KIND_POP, '0, '0);                  // pop on empty
    send_word(KIND_PUSH, '0, 32'h1234_5678);
    send_word(KIND_CLEAR, '0, '0);
    send_word(KIND_READ, 4'd0, '0);
  endtask

  // Zero capacity, one slot with overwrite, saturation above the ring size
  task automatic test_capacity_corners();
    set_capacity('0);
    send_word(KIND_PUSH, '0, 32'hDEAD_BEEF);
    send_word(KIND_POP, '0, '0);
    set_capacity(CNT_W'(1));
    send_word(KIND_PUSH, '0, 32'h0000_0001);
    send_word(KIND_PUSH, '0, 32'h8000_0000);      // overwrites the only entry
    send_word(KIND_READ, 4'd0, '0);
    send_word(KIND_POP, '0, '0);
    set_capacity('1);
    send_word(KIND_PUSH, '0, 32'hCAFE_F00D);
    set_capacity('1);                             // rewrite empties the ring
    send_word(KIND_READ, 4'd0, '0);
  endtask

  // Random traffic over several capacities with sender gaps
  task automatic test_random_traffic();
    logic [CNT_W-1:0] caps [10];
    int               n;
    bit               counted;
    bit               may_idle;
    caps = '{CNT_W'(DEPTH), CNT_W'(2), '1, CNT_W'(1), '0, CNT_W'(7), CNT_W'(17),
             CNT_W'($urandom_range(31, 0)), CNT_W'(3), CNT_W'(DEPTH)};
    foreach (caps[p]) begin
      set_capacity(caps[p]);
      n = 0;
      may_idle = 1'b1;
      while (n < 145) begin
        if (n % 40 == 0) may_idle = $urandom_range(2) != 0;
        if (may_idle && $urandom_range(5) == 0) pause_cycles($urandom_range(12, 1));
        send_random_word(counted);
        if (counted) n++;
        if (p == 4 && n == 70) drain_results();   // sender waits for the ring to go quiet
      end
    end
  endtask

  // Closing burst: back-to-back words, no gaps
  task automatic test_streaming();
    int n;
    bit counted;
    set_capacity(CNT_W'(DEPTH));
    n = 0;
    while (n < 170) begin
      send_random_word(counted);
      if (counted) n++;
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_kind    = '0;
    in_index   = '0;
    in_value   = '0;
    cfg_we     = 1'b0;
    cfg_data   = '0;
    mismatches = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_capacity_corners();
    test_random_traffic();
    test_streaming();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("overwriting_ring_buffer_top verification clean");
    end else begin
      $display("overwriting_ring_buffer_top verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("overwriting_ring_buffer_top verification failed");
    $finish;
  end

endmodule
